>>> hw/rtl/tbsc_pkg.sv
// Shared types and constants of the thresholded bright-spot centroid block.
`timescale 1ns / 1ps

package tbsc_pkg;

	localparam int PIX_W  = 8;
	localparam int DIM_W  = 13;
	localparam int CNT_W  = 25;
	localparam int SUM_W  = 36;
	localparam int REM_W  = CNT_W + 1;
	localparam int Q_W    = 16;
	localparam int STEP_W = 6;

	// Configuration register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_WIDTH     = 2'd1;
	localparam logic [1:0] REG_HEIGHT    = 2'd2;

	localparam logic [PIX_W-1:0] THR_RESET = 8'd240;
	localparam logic [DIM_W-1:0] W_RESET   = 13'd640;
	localparam logic [DIM_W-1:0] H_RESET   = 13'd480;

	// Largest value a 13-bit dimension register can hold
	localparam int DIM_REG_MAX = 8191;

	localparam logic [STEP_W-1:0] CENTROID_STEPS = 6'd36;
	localparam logic [STEP_W-1:0] NORM_STEPS     = 6'd15;

	localparam logic signed [Q_W-1:0] Q15_MAX = 16'sh7FFF;
	localparam logic signed [Q_W-1:0] Q15_MIN = 16'sh8000;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic signed [Q_W-1:0] x_position;
		logic signed [Q_W-1:0] y_position;
		logic [CNT_W-1:0]      bright_pixels;
		logic                  no_spot;
	} result_t;

endpackage

>>> hw/rtl/thresholded_bright_spot_centroid_top.sv
// Top level of the thresholded bright-spot centroid block.
// Pixel beats: one per cycle while idle; a pixel is done in the cycle it is accepted.
// Frame end: a restoring divider, one quotient bit per cycle, runs two 36-step centroid
// divisions, skipped when no pixel is bright, and two 15-step Q1.15 normalizations, each
// skipped when its coordinate saturates. Not ready meanwhile.
// Reset clears counters, sums and the sequencer; registers return to 240, 640 and 480.
`timescale 1ns / 1ps

module thresholded_bright_spot_centroid_top
	import tbsc_pkg::*;
#(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pixel_t           in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output result_t          out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	localparam int DIM_LIM = (MAX_DIMENSION < DIM_REG_MAX) ? MAX_DIMENSION : DIM_REG_MAX;
	localparam int CW      = (DIM_LIM > 1) ? $clog2(DIM_LIM) : 1;
	localparam logic [DIM_W-1:0] DIM_LIM_V = DIM_LIM[DIM_W-1:0];

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_PREP  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [1:0] OP_CX = 2'd0;
	localparam logic [1:0] OP_CY = 2'd1;
	localparam logic [1:0] OP_NX = 2'd2;
	localparam logic [1:0] OP_NY = 2'd3;

	logic [2:0]        state_q;
	logic [1:0]        op_q;
	logic [STEP_W-1:0] step_q;
	logic [PIX_W-1:0]  thr_q;
	logic [DIM_W-1:0]  wcfg_q, hcfg_q;
	logic [CW-1:0]     col_q, row_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  csum_q, rsum_q;
	logic              out_valid_q;

	logic [REM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  dvd_q, quo_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [SUM_W-1:0]  cx_q, cy_q;
	logic signed [Q_W-1:0] x_q, y_q;
	logic              neg_q, none_q;
	result_t           out_data_q;

	logic [DIM_W-1:0]  w_eff, h_eff;
	logic              in_fire, out_load, bright, col_end, row_end, frame_end;
	logic [PIX_W+1:0]  psum;
	logic [PIX_W+2:0]  thr3;

	assign w_eff = (wcfg_q == '0) ? DIM_W'(1) : ((wcfg_q > DIM_LIM_V) ? DIM_LIM_V : wcfg_q);
	assign h_eff = (hcfg_q == '0) ? DIM_W'(1) : ((hcfg_q > DIM_LIM_V) ? DIM_LIM_V : hcfg_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	// Take register writes only between pixels, with no frame-end work in flight
	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// floor(sum/3) > thr holds exactly when sum >= 3*thr + 3
	assign psum   = {2'b00, in_data.red} + {2'b00, in_data.green} + {2'b00, in_data.blue};
	assign thr3   = {2'b00, thr_q, 1'b0} + {3'b000, thr_q} + 11'd3;
	assign bright = ({1'b0, psum} >= thr3);

	assign col_end   = ({{(DIM_W+1-CW){1'b0}}, col_q} + 14'd1) >= {1'b0, w_eff};
	assign row_end   = ({{(DIM_W+1-CW){1'b0}}, row_q} + 14'd1) >= {1'b0, h_eff};
	assign frame_end = col_end && row_end;

	// Shared restoring divider step
	logic [REM_W-1:0] trial, rem_nx;
	logic             ge;
	logic [SUM_W-1:0] quo_nx;
	logic [Q_W-1:0]   norm_val;

	assign trial    = {rem_q[REM_W-2:0], dvd_q[SUM_W-1]};
	assign ge       = (trial >= {1'b0, dvs_q});
	assign rem_nx   = ge ? (trial - {1'b0, dvs_q}) : trial;
	assign quo_nx   = {quo_q[SUM_W-2:0], ge};
	assign norm_val = neg_q ? (Q_W'(0) - {1'b0, quo_nx[Q_W-2:0]}) : {1'b0, quo_nx[Q_W-2:0]};

	// Normalization setup: magnitude of 2*c - d, sign and saturation
	logic [SUM_W-1:0] c_sel, d_ext;
	logic [SUM_W:0]   a2, d2;
	logic [DIM_W-1:0] d_sel, mag;
	logic             a_ge_d, a_gt_d, c_ge_d, c_zero, p_neg, p_sat;

	assign c_sel  = (op_q == OP_NX) ? cx_q : cy_q;
	assign d_sel  = (op_q == OP_NX) ? w_eff : h_eff;
	assign d_ext  = {{(SUM_W-DIM_W){1'b0}}, d_sel};
	assign a2     = {c_sel, 1'b0};
	assign d2     = {1'b0, d_ext};
	assign a_ge_d = (a2 >= d2);
	assign a_gt_d = (a2 > d2);
	assign c_ge_d = (c_sel >= d_ext);
	assign c_zero = (c_sel == '0);
	assign mag    = a_ge_d ? (a2[DIM_W-1:0] - d_sel) : (d_sel - a2[DIM_W-1:0]);
	assign p_neg  = (op_q == OP_NX) ? !a_ge_d : a_gt_d;
	assign p_sat  = (op_q == OP_NX) ? (a_ge_d ? c_ge_d : c_zero)
	                                : (a_gt_d ? c_ge_d : c_zero);

	// Control: configuration, counters, accumulators, sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_CX;
			step_q      <= '0;
			thr_q       <= THR_RESET;
			wcfg_q      <= W_RESET;
			hcfg_q      <= H_RESET;
			col_q       <= '0;
			row_q       <= '0;
			cnt_q       <= '0;
			csum_q      <= '0;
			rsum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_THRESHOLD: thr_q  <= cfg_data[PIX_W-1:0];
					REG_WIDTH:     wcfg_q <= cfg_data;
					REG_HEIGHT:    hcfg_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (bright) begin
							cnt_q  <= cnt_q + CNT_W'(1);
							csum_q <= csum_q + {{(SUM_W-CW){1'b0}}, col_q};
							rsum_q <= rsum_q + {{(SUM_W-CW){1'b0}}, row_q};
						end
						if (!col_end) begin
							col_q <= col_q + CW'(1);
						end else begin
							col_q <= '0;
							if (!row_end) begin
								row_q <= row_q + CW'(1);
							end else begin
								row_q   <= '0;
								state_q <= ST_START;
							end
						end
					end
				end
				ST_START: begin
					if (cnt_q == '0) begin
						op_q    <= OP_NX;
						state_q <= ST_PREP;
					end else begin
						op_q    <= OP_CX;
						step_q  <= CENTROID_STEPS;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == STEP_W'(1)) begin
						case (op_q)
							OP_CX: begin
								op_q   <= OP_CY;
								step_q <= CENTROID_STEPS;
							end
							OP_CY: begin
								op_q    <= OP_NX;
								state_q <= ST_PREP;
							end
							OP_NX: begin
								op_q    <= OP_NY;
								state_q <= ST_PREP;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_PREP: begin
					if (p_sat) begin
						if (op_q == OP_NX) begin
							op_q <= OP_NY;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						step_q  <= NORM_STEPS;
						state_q <= ST_DIV;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						cnt_q   <= '0;
						csum_q  <= '0;
						rsum_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: divider registers, centroid, normalized coordinates, result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_START: begin
				none_q <= (cnt_q == '0);
				cx_q   <= {{(SUM_W-DIM_W+1){1'b0}}, w_eff[DIM_W-1:1]};
				cy_q   <= {{(SUM_W-DIM_W+1){1'b0}}, h_eff[DIM_W-1:1]};
				rem_q  <= '0;
				dvd_q  <= csum_q;
				dvs_q  <= cnt_q;
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
				quo_q <= quo_nx;
				if (step_q == STEP_W'(1)) begin
					case (op_q)
						OP_CX: begin
							cx_q  <= quo_nx;
							rem_q <= '0;
							dvd_q <= rsum_q;
						end
						OP_CY:   cy_q <= quo_nx;
						OP_NX:   x_q  <= norm_val;
						default: y_q  <= norm_val;
					endcase
				end
			end
			ST_PREP: begin
				if (p_sat) begin
					if (op_q == OP_NX) begin
						x_q <= p_neg ? Q15_MIN : Q15_MAX;
					end else begin
						y_q <= p_neg ? Q15_MIN : Q15_MAX;
					end
				end else begin
					// dividend is mag * 2^15: start from mag and shift in zeros
					rem_q <= {{(REM_W-DIM_W){1'b0}}, mag};
					dvd_q <= '0;
					dvs_q <= {{(CNT_W-DIM_W){1'b0}}, d_sel};
					neg_q <= p_neg;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					out_data_q.x_position    <= x_q;
					out_data_q.y_position    <= y_q;
					out_data_q.bright_pixels <= cnt_q;
					out_data_q.no_spot       <= none_q;
				end
			end
			default: ;
		endcase
	end

	a_frame_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && frame_end |=> !in_ready)
		else $error("pixel accepted right after frame end");

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> step_q != '0)
		else $error("divider running with no steps left");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < {1'b0, dvs_q})
		else $error("divider remainder not below divisor");

	a_no_spot_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.no_spot |-> out_data.bright_pixels == '0)
		else $error("no_spot reported with bright pixels");

endmodule

>>> bench/thresholded_bright_spot_centroid_top_test.sv
// Self-checking bench for the bright-spot centroid block: directed corners, then random frames.
`timescale 1ns / 1ps

module thresholded_bright_spot_centroid_top_test;
	import tbsc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 740;
	localparam int QUIET_TAIL = 120;
	localparam int MAX_DIM = 4096;
	localparam int CLAMP_RUN = 20;
	localparam logic [1:0] REG_NONE = 2'd3;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	pixel_t           in_data;
	logic             out_valid;
	logic             out_ready;
	result_t          out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [DIM_W-1:0] cfg_data;

	// Mirror of the block's registers and frame accumulators
	logic [PIX_W-1:0] thr_reg;
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	int unsigned      col_pos;
	int unsigned      row_pos;
	logic [CNT_W-1:0] lit_count;
	logic [SUM_W-1:0] col_total;
	logic [SUM_W-1:0] row_total;

	result_t centroids_due[$];
	result_t due;
	int      errors = 0;
	bit      gaps_on = 1'b1;
	bit      hold_sink = 1'b0;

	thresholded_bright_spot_centroid_top #(
		.MAX_DIMENSION(MAX_DIM)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned usable_dim(logic [DIM_W-1:0] d);
		if (d == 0) begin
			return 1;
		end
		if (d > MAX_DIM) begin
			return MAX_DIM;
		end
		return d;
	endfunction

	function automatic logic signed [Q_W-1:0] unit_q15(longint num, longint den);
		longint q;
		q = num * 32768 / den;
		if (q > 32767) begin
			q = 32767;
		end else if (q < -32768) begin
			q = -32768;
		end
		return q[Q_W-1:0];
	endfunction

	// Accumulate one pixel; queue the centroid when it closes the frame
	function automatic void track_pixel(pixel_t px);
		int unsigned w;
		int unsigned h;
		int unsigned gray;
		longint      cx;
		longint      cy;
		result_t     r;
		w = usable_dim(width_reg);
		h = usable_dim(height_reg);
		gray = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
		if (gray > thr_reg) begin
			lit_count = lit_count + 1'b1;
			col_total = col_total + col_pos;
			row_total = row_total + row_pos;
		end
		if (col_pos + 1 < w) begin
			col_pos++;
			return;
		end
		col_pos = 0;
		if (row_pos + 1 < h) begin
			row_pos++;
			return;
		end
		row_pos = 0;
		r.no_spot = (lit_count == 0);
		if (r.no_spot) begin
			cx = w / 2;
			cy = h / 2;
		end else begin
			cx = col_total / lit_count;
			cy = row_total / lit_count;
		end
		r.x_position = unit_q15(2 * cx - longint'(w), longint'(w));
		r.y_position = unit_q15(longint'(h) - 2 * cy, longint'(h));
		r.bright_pixels = lit_count;
		centroids_due.push_back(r);
		lit_count = '0;
		col_total = '0;
		row_total = '0;
	endfunction

	function automatic logic [PIX_W-1:0] near_threshold();
		int lvl;
		lvl = int'(thr_reg) + int'($urandom_range(0, 4)) - 2;
		if (lvl < 0) begin
			lvl = 0;
		end
		if (lvl > 255) begin
			lvl = 255;
		end
		return lvl[PIX_W-1:0];
	endfunction

	// Dark pixels never exceed the threshold; others are raw, near the edge or bright
	function automatic pixel_t pick_pixel(bit dark);
		pixel_t px;
		if (dark) begin
			px.red = $urandom_range(0, thr_reg);
			px.green = $urandom_range(0, thr_reg);
			px.blue = $urandom_range(0, thr_reg);
			return px;
		end
		case ($urandom_range(0, 2))
			0: px = $urandom;
			1: begin
				px.red = near_threshold();
				px.green = near_threshold();
				px.blue = near_threshold();
			end
			default: begin
				px.red = $urandom_range(thr_reg, 255);
				px.green = $urandom_range(thr_reg, 255);
				px.blue = $urandom_range(thr_reg, 255);
			end
		endcase
		return px;
	endfunction

	// Upper data bits are random; the register keeps only the low byte
	function automatic logic [DIM_W-1:0] pick_threshold();
		logic [DIM_W-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 7))
			0: v[PIX_W-1:0] = '0;
			1: v[PIX_W-1:0] = '1;
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom_range(6, 16);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic push_pixel(pixel_t px);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		do @(posedge clk); while (!in_ready);
		track_pixel(px);
	endtask

	// Drop valid and wait until every centroid is out
	task automatic settle();
		in_valid <= 1'b0;
		while (centroids_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_THRESHOLD: thr_reg = val[PIX_W-1:0];
			REG_WIDTH:     width_reg = val;
			REG_HEIGHT:    height_reg = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_registers();
		push_pixel({8'd240, 8'd240, 8'd240});
		push_pixel({8'd241, 8'd241, 8'd241});
		push_pixel({8'd240, 8'd241, 8'd241});
		settle();
		// shrink the 640x480 default so the open row closes on the next beat
		write_reg(REG_WIDTH, 13'd2);
		write_reg(REG_HEIGHT, 13'd1);
		push_pixel({8'd255, 8'd0, 8'd0});
		settle();
	endtask

	task automatic test_corner_pixels();
		write_reg(REG_WIDTH, 13'd0);
		write_reg(REG_HEIGHT, 13'd0);
		write_reg(REG_THRESHOLD, 13'd0);
		push_pixel('0);
		push_pixel({8'd0, 8'd0, 8'd2});
		push_pixel({8'd0, 8'd1, 8'd2});
		push_pixel({8'd1, 8'd1, 8'd1});
		settle();
		write_reg(REG_THRESHOLD, 13'd255);
		push_pixel({3{8'hFF}});
		settle();
		write_reg(REG_THRESHOLD, 13'd254);
		push_pixel({8'd255, 8'd255, 8'd254});
		push_pixel({3{8'hFF}});
		settle();
		write_reg(REG_THRESHOLD, 13'h1F80);
		push_pixel({8'd128, 8'd128, 8'd129});
		push_pixel({3{8'd129}});
		settle();
	endtask

	// Oversized dimensions must not close rows or frames early; shrink to end the frame
	task automatic test_dimension_clamp();
		write_reg(REG_THRESHOLD, 13'd128);
		write_reg(REG_WIDTH, 13'd8191);
		write_reg(REG_HEIGHT, 13'd1);
		repeat (CLAMP_RUN) push_pixel(pick_pixel(1'b0));
		settle();
		write_reg(REG_WIDTH, 13'd2);
		push_pixel(pick_pixel(1'b0));
		settle();
		write_reg(REG_WIDTH, 13'd1);
		write_reg(REG_HEIGHT, 13'd4097);
		repeat (CLAMP_RUN) push_pixel(pick_pixel(1'b0));
		settle();
		write_reg(REG_HEIGHT, 13'd1);
		push_pixel(pick_pixel(1'b0));
		settle();
	endtask

	task automatic test_shrink_mid_frame();
		write_reg(REG_THRESHOLD, 13'd100);
		write_reg(REG_WIDTH, 13'd4);
		write_reg(REG_HEIGHT, 13'd2);
		repeat (4) push_pixel({3{8'hFF}});
		settle();
		// centroid column now lies past a one-pixel row
		write_reg(REG_WIDTH, 13'd1);
		push_pixel('0);
		settle();
		write_reg(REG_HEIGHT, 13'd6);
		repeat (3) push_pixel('0);
		push_pixel({3{8'hFF}});
		settle();
		// row counter already past the new height: frame ends on the next beat
		write_reg(REG_HEIGHT, 13'd1);
		push_pixel('0);
		settle();
	endtask

	task automatic test_unused_index();
		write_reg(REG_NONE, 13'h1FFF);
		write_reg(REG_NONE, 13'h0000);
		repeat (2) push_pixel(pick_pixel(1'b0));
		settle();
	endtask

	task automatic test_output_stall();
		write_reg(REG_WIDTH, 13'd2);
		write_reg(REG_HEIGHT, 13'd1);
		hold_sink = 1'b1;
		repeat (40) push_pixel(pick_pixel(1'b0));
		settle();
	endtask

	task automatic test_random_frames();
		int sent;
		int frames;
		int pixels;
		bit dark;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= RANDOM_ITEMS - 150) begin
				gaps_on = 1'b0;
			end
			settle();
			write_reg(REG_THRESHOLD, pick_threshold());
			write_reg(REG_WIDTH, pick_dim());
			write_reg(REG_HEIGHT, pick_dim());
			frames = $urandom_range(1, 4);
			repeat (frames) begin
				dark = ($urandom_range(0, 5) == 0);
				pixels = usable_dim(width_reg) * usable_dim(height_reg);
				for (int i = 0; i < pixels; i++) begin
					if ($urandom_range(0, 99) == 0) begin
						settle();
						write_reg($urandom_range(0, 1) ? REG_WIDTH : REG_HEIGHT, pick_dim());
					end
					push_pixel(pick_pixel(dark));
				end
				sent += pixels;
				if ($urandom_range(0, 7) == 0) begin
					settle();
				end
			end
		end
	endtask

	// Result side: random stalls, plus one long hold on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_sink = 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (centroids_due.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d bright=%0d none=%0b", $time,
					out_data.x_position, out_data.y_position, out_data.bright_pixels,
					out_data.no_spot);
				errors++;
			end else begin
				due = centroids_due.pop_front();
				check_field("x_position", due.x_position, out_data.x_position);
				check_field("y_position", due.y_position, out_data.y_position);
				check_field("bright_pixels", due.bright_pixels, out_data.bright_pixels);
				check_field("no_spot", due.no_spot, out_data.no_spot);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
		$display("thresholded_bright_spot_centroid_top test failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_THRESHOLD;
		cfg_data <= '0;
		thr_reg = THR_RESET;
		width_reg = W_RESET;
		height_reg = H_RESET;
		col_pos = 0;
		row_pos = 0;
		lit_count = '0;
		col_total = '0;
		row_total = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_registers();
		test_corner_pixels();
		test_shrink_mid_frame();
		test_unused_index();
		test_dimension_clamp();
		test_output_stall();
		test_random_frames();
		settle();
		repeat (QUIET_TAIL) @(posedge clk);
		if (errors == 0 && centroids_due.size() == 0) begin
			$display("thresholded_bright_spot_centroid_top test passed");
		end else begin
			$display("thresholded_bright_spot_centroid_top test failed");
		end
		$finish;
	end

endmodule
